/* src/exact_grid_cell_index_macros.svh */
// ----------------------------------------------------------------------------
// exact grid cell index assertion macros
// shared assertion wrappers, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef EXACT_GRID_CELL_INDEX_MACROS_SVH
`define EXACT_GRID_CELL_INDEX_MACROS_SVH
`ifndef NO_ASSERTIONS
`define EGCI_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define EGCI_ASSERT_NXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`else
`define EGCI_ASSERT_IMP(label, clk, rst_n, a, c)
`define EGCI_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

/* src/egci_pkg.sv */
// ----------------------------------------------------------------------------
// egci_pkg
// shared types and constants of the exact grid cell index pipeline
// ----------------------------------------------------------------------------
`default_nettype none
package egci_pkg;
	localparam int QuotBits = 66;
	localparam int DivSteps = 65;
	localparam int DefStepsPerStage = 4;
	localparam logic [63:0] TopBit = 64'h8000_0000_0000_0000;
	localparam logic [63:0] MaxPos = 64'h7FFF_FFFF_FFFF_FFFF;

	typedef enum logic [1:0] {
		REG_CELL_SIZE = 2'd0,
		REG_MAX_MAG   = 2'd1,
		REG_MODE      = 2'd2
	} reg_idx_t;

	// control carried with each item
	typedef struct packed {
		logic neg;
		logic node;
		logic inval;
		logic zero;
		logic over;
	} ctl_t;

	// normalize a finite nonzero magnitude to mantissa in [2^52,2^53) and exponent
	function automatic logic [65:0] decode(input logic [62:0] b);
		logic [52:0] m;
		logic [5:0] lz;
		logic signed [12:0] e;
		m = (b[62:52] == 11'd0) ? {1'b0, b[51:0]} : {1'b1, b[51:0]};
		lz = 6'd0;
		for (int i = 52; i >= 0; i--) begin
			if (m[i] && lz == 6'd0 && !(|(m >> (i + 1)))) lz = 6'(52 - i);
		end
		if (b[62:52] == 11'd0) e = 13'sd1 - 13'sd1075 - $signed({7'd0, lz});
		else e = $signed({2'b0, b[62:52]}) - 13'sd1075;
		decode = {m << lz, e};
	endfunction
endpackage
`default_nettype wire

/* src/egci_front.sv */
// ----------------------------------------------------------------------------
// egci_front
// classification, operand decode and exponent difference (two stages)
// ----------------------------------------------------------------------------
`default_nettype none
module egci_front (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_vld,
	input  wire logic [63:0] x,
	input  wire logic [63:0] cs,
	input  wire logic [63:0] mm,
	input  wire logic mode,
	output logic vld_s2,
	output egci_pkg::ctl_t ctl_s2,
	output logic [52:0] mx_s2,
	output logic [52:0] ms_s2,
	output logic signed [13:0] d_s2
);
	import egci_pkg::*;
	logic vld_s1;
	ctl_t ctl_s1;
	logic [62:0] ax_s1, as_s1;
	logic [65:0] dx, ds;
	logic le, bad;

	// magnitude compare as ordered integers; nan max rejects all
	assign le = !(mm[62:52] == 11'h7FF && mm[51:0] != 52'd0) &&
		!(x[62:52] == 11'h7FF && x[51:0] != 52'd0) &&
		(mm[63] ? (x[62:0] == 63'd0 && mm[62:0] == 63'd0) : (x[62:0] <= mm[62:0]));
	assign bad = cs[63] || cs == 64'd0 || cs[62:52] == 11'h7FF;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else vld_s1 <= in_vld;
	end
	always_ff @(posedge clk) begin
		ctl_s1.neg <= x[63];
		ctl_s1.node <= mode;
		ctl_s1.inval <= !le || bad;
		ctl_s1.zero <= x[62:0] == 63'd0;
		ctl_s1.over <= x[62:52] == 11'h7FF;
		ax_s1 <= x[62:0];
		as_s1 <= cs[62:0];
	end

	assign dx = decode(ax_s1);
	assign ds = decode(as_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else vld_s2 <= vld_s1;
	end
	always_ff @(posedge clk) begin
		ctl_s2 <= ctl_s1;
		mx_s2 <= dx[65:13];
		ms_s2 <= ds[65:13];
		d_s2 <= 14'($signed(dx[12:0]) - $signed(ds[12:0]) + $signed({13'd0, ctl_s1.node}));
	end
endmodule
`default_nettype wire

/* src/egci_div.sv */
// ----------------------------------------------------------------------------
// egci_div
// pipelined restoring divider, StepsPerStage quotient bits per stage
// ----------------------------------------------------------------------------
`default_nettype none
module egci_div #(
	parameter int StepsPerStage = egci_pkg::DefStepsPerStage
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic vld_in,
	input  wire egci_pkg::ctl_t ctl_in,
	input  wire logic [52:0] mx,
	input  wire logic [52:0] ms,
	input  wire logic signed [13:0] d,
	output logic vld_out,
	output egci_pkg::ctl_t ctl_out,
	output logic [egci_pkg::QuotBits-1:0] q_out,
	output logic rem_out
);
	import egci_pkg::*;
	localparam int NStg = (DivSteps + StepsPerStage - 1) / StepsPerStage;

	logic vld_p [NStg+1];
	ctl_t ctl_p [NStg+1];
	logic [QuotBits-1:0] q_p [NStg+1];
	logic [53:0] r_p [NStg+1];
	logic [52:0] ms_p [NStg+1];
	logic [7:0] n_p [NStg+1];
	logic ov_p [NStg+1];
	logic lt_p [NStg+1];

	// n = remaining shift steps (d clipped); d<0 means quotient zero
	always_comb begin
		vld_p[0] = vld_in;
		ctl_p[0] = ctl_in;
		ms_p[0] = ms;
		lt_p[0] = d < 0;
		ov_p[0] = d >= 14'sd65;
		n_p[0] = (d < 0 || d >= 14'sd65) ? 8'd0 : 8'(d);
		q_p[0] = {{(QuotBits-1){1'b0}}, (mx >= ms) && d >= 0};
		r_p[0] = {1'b0, (mx >= ms) ? mx - ms : mx};
	end

	for (genvar g = 0; g < NStg; g++) begin : g_stg
		logic [QuotBits-1:0] qc;
		logic [53:0] rc;
		logic [7:0] nc;
		logic oc;
		always_comb begin
			qc = q_p[g];
			rc = r_p[g];
			nc = n_p[g];
			oc = ov_p[g];
			for (int k = 0; k < StepsPerStage; k++) begin
				if (nc != 8'd0) begin
					if (qc[63]) oc = 1'b1;
					rc = rc << 1;
					qc = qc << 1;
					if (rc >= {1'b0, ms_p[g]}) begin
						rc = rc - {1'b0, ms_p[g]};
						qc[0] = 1'b1;
					end
					nc = nc - 8'd1;
				end
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_p[g+1] <= 1'b0;
			else vld_p[g+1] <= vld_p[g];
		end
		always_ff @(posedge clk) begin
			ctl_p[g+1] <= ctl_p[g];
			q_p[g+1] <= qc;
			r_p[g+1] <= rc;
			n_p[g+1] <= nc;
			ov_p[g+1] <= oc;
			ms_p[g+1] <= ms_p[g];
			lt_p[g+1] <= lt_p[g];
		end
	end

	always_comb begin
		vld_out = vld_p[NStg];
		ctl_out = ctl_p[NStg];
		ctl_out.over = ctl_p[NStg].over || ov_p[NStg];
		q_out = lt_p[NStg] ? '0 : q_p[NStg];
		rem_out = lt_p[NStg] || (r_p[NStg] != 54'd0);
	end
endmodule
`default_nettype wire

/* src/egci_final.sv */
// ----------------------------------------------------------------------------
// egci_final
// rounding to cell or node, sign and saturation, output register
// ----------------------------------------------------------------------------
`default_nettype none
module egci_final (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic vld_in,
	input  wire egci_pkg::ctl_t ctl_in,
	input  wire logic [egci_pkg::QuotBits-1:0] q,
	input  wire logic rem,
	output logic done,
	output logic [63:0] cell_index,
	output logic invalid
);
	import egci_pkg::*;
	logic [63:0] a, mag, res;
	always_comb begin
		a = q[63:0];
		mag = 64'd0;
		res = 64'd0;
		if (ctl_in.inval || ctl_in.zero) res = 64'd0;
		else if (ctl_in.over) res = ctl_in.neg ? TopBit : MaxPos;
		else if (!ctl_in.neg) begin
			mag = ctl_in.node ? (a >> 1) + {63'd0, a[0]} : a;
			res = (mag > MaxPos) ? MaxPos : mag;
		end else begin
			if (ctl_in.node) mag = (a >> 1) + {63'd0, a[0] & rem};
			else mag = a + {63'd0, rem};
			if (!ctl_in.node && a > TopBit) res = TopBit;
			else res = (mag > TopBit) ? TopBit : 64'd0 - mag;
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= vld_in;
	end
	always_ff @(posedge clk) begin
		cell_index <= res;
		invalid <= ctl_in.inval;
	end
endmodule
`default_nettype wire

/* src/exact_grid_cell_index.sv */
// exact grid cell index: floor(x / cell size) or nearest node, exact
// pipeline: 2 decode stages + ceil(65/StepsPerStage) divider stages + 1 output
// stage (the default is four quotient bits per divider stage)
// throughput: one coordinate per cycle, set by the fully pipelined divider
// reset clears valid bits and loads cell size 1.0, max +inf, cell mode
// results leave on done for one cycle; the receiver cannot stall
`default_nettype none
`include "exact_grid_cell_index_macros.svh"
module exact_grid_cell_index #(
	parameter int StepsPerStage = egci_pkg::DefStepsPerStage
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic busy,
	input  wire logic [63:0] position_bits,
	output logic done,
	output logic signed [63:0] cell_index,
	output logic invalid,
	input  wire logic cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [63:0] cfg_data
);
	import egci_pkg::*;
	logic [63:0] cell_size_bits_q, max_magnitude_bits_q;
	logic rounding_mode_q;
	logic vld2, vldd;
	ctl_t c2, cd;
	logic [52:0] mx2, ms2;
	logic signed [13:0] d2;
	logic [QuotBits-1:0] qd;
	logic remd;
	logic [63:0] idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_size_bits_q <= 64'h3FF0_0000_0000_0000;
			max_magnitude_bits_q <= 64'h7FF0_0000_0000_0000;
			rounding_mode_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CELL_SIZE: cell_size_bits_q <= cfg_data;
				REG_MAX_MAG: max_magnitude_bits_q <= cfg_data;
				REG_MODE: rounding_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	egci_front u_front (
		.clk(clk), .arst_n(arst_n), .in_vld(start && !busy), .x(position_bits),
		.cs(cell_size_bits_q), .mm(max_magnitude_bits_q), .mode(rounding_mode_q),
		.vld_s2(vld2), .ctl_s2(c2), .mx_s2(mx2), .ms_s2(ms2), .d_s2(d2)
	);
	egci_div #(.StepsPerStage(StepsPerStage)) u_div (
		.clk(clk), .arst_n(arst_n), .vld_in(vld2), .ctl_in(c2), .mx(mx2), .ms(ms2),
		.d(d2), .vld_out(vldd), .ctl_out(cd), .q_out(qd), .rem_out(remd)
	);
	egci_final u_final (
		.clk(clk), .arst_n(arst_n), .vld_in(vldd), .ctl_in(cd), .q(qd), .rem(remd),
		.done(done), .cell_index(idx), .invalid(invalid)
	);
	assign cell_index = $signed(idx);

	`EGCI_ASSERT_IMP(a_inv_zero, clk, arst_n, done && invalid, cell_index == 64'sd0)
	`EGCI_ASSERT_NXT(a_done_from_div, clk, arst_n, !vldd, !done)
	`EGCI_ASSERT_IMP(a_zero_in, clk, arst_n, vldd && cd.zero && !cd.inval, !cd.over)
endmodule
`default_nettype wire

/* test/tb.sv */
// ----------------------------------------------------------------------------
// exact grid cell index testbench
// drives double coordinates under several cell size, limit and mode settings,
// predicts the exact floor or nearest node index, checks every result in order
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
	import egci_pkg::*;

	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 40;
	localparam int STALL_LIMIT = 4000;

	class cell_index_scoreboard;
		logic [63:0] cell_width;
		logic [63:0] max_mag;
		logic node_mode;
		logic [63:0] index_q[$];
		logic invalid_q[$];

		function new();
			cell_width = 64'h3FF0_0000_0000_0000;
			max_mag = 64'h7FF0_0000_0000_0000;
			node_mode = 1'b0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [63:0] val);
			case (idx)
				REG_CELL_SIZE: cell_width = val;
				REG_MAX_MAG: max_mag = val;
				REG_MODE: node_mode = val[0];
				default: ;
			endcase
		endfunction

		// mantissa in [2^52, 2^53) with matching exponent
		function void normalize(logic [63:0] b, output logic [63:0] m, output int e);
			m = {12'd0, b[51:0]};
			if (b[62:52] == 11'd0) begin
				e = -1074;
			end else begin
				m[52] = 1'b1;
				e = int'(b[62:52]) - 1075;
			end
			while (m[52] == 1'b0) begin
				m = m << 1;
				e--;
			end
		endfunction

		function logic [63:0] floor_quotient(logic [63:0] mx, int ex, logic [63:0] ms, int es,
				output bit over, output bit rem);
			int d;
			logic [63:0] q;
			logic [63:0] r;
			d = ex - es;
			over = 0;
			rem = 0;
			if (d >= 65) begin
				over = 1;
				return 64'd0;
			end
			if (d <= -1) begin
				rem = 1;
				return 64'd0;
			end
			q = (mx >= ms) ? 64'd1 : 64'd0;
			r = q[0] ? mx - ms : mx;
			for (int i = 0; i < d; i++) begin
				if (q[63]) over = 1;
				r = r << 1;
				q = q << 1;
				if (r >= ms) begin
					r = r - ms;
					q[0] = 1'b1;
				end
			end
			rem = (r != 64'd0);
			return q;
		endfunction

		function bit within_limit(logic [63:0] ax);
			if (ax[62:52] == 11'h7FF && ax[51:0] != 0) return 0;
			if (max_mag[62:52] == 11'h7FF && max_mag[51:0] != 0) return 0;
			if (max_mag[63]) return (ax == 64'd0 && max_mag[62:0] == 63'd0);
			return ax <= max_mag;
		endfunction

		function void note(logic [63:0] xb);
			logic [63:0] ax, mx, ms, a, mag, idx;
			int ex, es;
			bit neg, over, rem, bad;
			ax = xb & ~TopBit;
			neg = xb[63];
			idx = 64'd0;
			bad = !within_limit(ax) || cell_width[63] || cell_width == 64'd0 ||
				cell_width[62:52] == 11'h7FF;
			if (!bad && ax != 64'd0) begin
				if (ax[62:52] == 11'h7FF) begin
					over = 1;
					a = 0;
					rem = 0;
				end else begin
					normalize(ax, mx, ex);
					normalize(cell_width, ms, es);
					if (node_mode) es--;
					a = floor_quotient(mx, ex, ms, es, over, rem);
				end
				if (over) begin
					idx = neg ? TopBit : MaxPos;
				end else if (!neg) begin
					mag = node_mode ? (a >> 1) + {63'd0, a[0]} : a;
					idx = (mag > MaxPos) ? MaxPos : mag;
				end else if (!node_mode && a > TopBit) begin
					idx = TopBit;
				end else begin
					if (node_mode) mag = (a >> 1) + {63'd0, a[0] & rem};
					else mag = a + {63'd0, rem};
					idx = (mag > TopBit) ? TopBit : (64'd0 - mag);
				end
			end
			index_q.push_back(idx);
			invalid_q.push_back(bad);
		endfunction

		// returns 1 when the result matches the oldest expectation
		function bit check(logic [63:0] idx, logic inv, output string msg);
			logic [63:0] e_idx;
			logic e_inv;
			if (index_q.size() == 0) begin
				msg = $sformatf("result with nothing expected: index %h invalid %b", idx, inv);
				return 0;
			end
			e_idx = index_q.pop_front();
			e_inv = invalid_q.pop_front();
			if (idx !== e_idx || inv !== e_inv) begin
				msg = $sformatf("index %h invalid %b, expected index %h invalid %b",
					idx, inv, e_idx, e_inv);
				return 0;
			end
			return 1;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [63:0] position_bits = 64'd0;
	logic done;
	logic signed [63:0] cell_index;
	logic invalid;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = REG_CELL_SIZE;
	logic [63:0] cfg_data = 64'd0;

	cell_index_scoreboard sb = new();
	int errors = 0;
	int stall_cycles = 0;

	exact_grid_cell_index dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.position_bits(position_bits),
		.done(done),
		.cell_index(cell_index),
		.invalid(invalid),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task report(string msg);
		errors++;
		$display("mismatch at %0t: %s", $time, msg);
	endtask

	always @(posedge clk) begin
		string msg;
		if (arst_n) begin
			if (start && !busy) sb.note(position_bits);
			if (done && !sb.check(cell_index, invalid, msg)) report(msg);
			if ((start && !busy) || done) stall_cycles <= 0;
			else stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("exact_grid_cell_index verification failed");
				$finish;
			end
		end
	end

	task write_reg(logic [1:0] idx, logic [63:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		sb.set_reg(idx, val);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// idle cycles after a transfer, zero for back to back
	function int random_gap();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 60) return 0;
		return (pick < 92) ? int'($urandom_range(1, 3)) : int'($urandom_range(10, 40));
	endfunction

	// one transfer of a coordinate, entered at a falling edge; start stays high while busy
	task send_position(logic [63:0] xb);
		int gap;
		start <= 1'b1;
		position_bits <= xb;
		do @(posedge clk); while (busy);
		@(negedge clk);
		gap = random_gap();
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task drain();
		start <= 1'b0;
		while (sb.index_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function logic [63:0] pick_position();
		real cs, v;
		logic [63:0] b;
		int k, ex;
		cs = (sb.cell_width[62:52] == 11'h7FF || sb.cell_width[63] || sb.cell_width == 0) ?
			1.0 : $bitstoreal(sb.cell_width);
		case ($urandom_range(0, 9))
			0, 1, 2: b = {$urandom(), $urandom()};
			3, 4, 5: begin
				// around cell borders and half-cell points
				k = int'($urandom_range(0, 4000)) - 2000;
				v = (real'(k) + (($urandom_range(0, 1) == 1) ? 0.5 : 0.0)) * cs;
				b = $realtobits(v);
				if (b[62:0] != 0) b = b + 64'(int'($urandom_range(0, 2)) - 1);
			end
			6: b = $realtobits((real'($urandom_range(0, 400)) - 200.0) / 8.0);
			7: begin
				ex = int'(sb.cell_width[62:52]) + int'($urandom_range(0, 140)) - 70;
				if (ex < 0) ex = 0;
				if (ex > 2046) ex = 2046;
				b = {1'($urandom()), 11'(ex), 20'($urandom()), $urandom()};
			end
			8: case ($urandom_range(0, 5))
				0: b = 64'h7FF0_0000_0000_0000;
				1: b = 64'hFFF0_0000_0000_0000;
				2: b = 64'h7FF8_0000_0000_0001;
				3: b = {$urandom_range(0, 1) == 1, 63'd0};
				4: b = {$urandom_range(0, 1) == 1, 63'h7FEF_FFFF_FFFF_FFFF};
				default: b = {$urandom_range(0, 1) == 1, 63'd1};
			endcase
			default: b = {1'($urandom()), 11'($urandom_range(1090, 2046)), 20'($urandom()),
				$urandom()};
		endcase
		return b;
	endfunction

	logic [63:0] cell_set[10] = '{64'h3FF0_0000_0000_0000, 64'h3FB9_9999_9999_999A,
		64'h4008_0000_0000_0000, 64'h0000_0000_0000_0001, 64'h7FEF_FFFF_FFFF_FFFF,
		64'h0000_0000_0000_0000, 64'hBFF0_0000_0000_0000, 64'h7FF0_0000_0000_0000,
		64'h3F50_0000_0000_0003, 64'h000F_FFFF_FFFF_FFFF};
	logic [63:0] limit_set[6] = '{64'h7FF0_0000_0000_0000, 64'h4059_0000_0000_0000,
		64'h7FF8_0000_0000_0000, 64'hBFF0_0000_0000_0000, 64'h8000_0000_0000_0000,
		64'h7FEF_FFFF_FFFF_FFFF};

	initial begin
		logic [63:0] directed[$];
		directed = '{64'h0, 64'h8000_0000_0000_0000, 64'h7FF0_0000_0000_0000,
			64'hFFF0_0000_0000_0000, 64'h7FF8_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
			64'h7FEF_FFFF_FFFF_FFFF, 64'hFFEF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001,
			64'h8000_0000_0000_0001, 64'h3FF0_0000_0000_0000, 64'hBFF0_0000_0000_0000,
			64'h3FE0_0000_0000_0000, 64'hBFE0_0000_0000_0000, 64'h3FF8_0000_0000_0000,
			64'hBFF8_0000_0000_0000, 64'h43E0_0000_0000_0000, 64'hC3E0_0000_0000_0000,
			64'h43DF_FFFF_FFFF_FFFF, 64'hC3F0_0000_0000_0000};
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings, then nearest-node mode, with the boundary values
		foreach (directed[i]) send_position(directed[i]);
		drain();
		write_reg(REG_MODE, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(REG_UNUSED, 64'h1234_5678_9ABC_DEF0);
		foreach (directed[i]) send_position(directed[i]);
		drain();

		for (int ph = 0; ph < 14; ph++) begin
			write_reg(REG_CELL_SIZE, ph < 10 ? cell_set[ph] :
				{1'b0, 11'($urandom_range(0, 2046)), 20'($urandom()), $urandom()});
			write_reg(REG_MAX_MAG, (ph % 3 == 0) ? limit_set[$urandom_range(0, 5)] :
				64'h7FF0_0000_0000_0000);
			write_reg(REG_MODE, 64'($urandom_range(0, 1)));
			repeat (36) send_position(pick_position());
			drain();
		end

		if (errors == 0) $display("exact_grid_cell_index verification clean");
		else $display("exact_grid_cell_index verification failed");
		$finish;
	end
endmodule
`default_nettype wire
